### design/ecid_pkg.sv
// Shared constants, types and cosh table for the electron cut ID selector.
package ecid_pkg;

    localparam int COSH_TABLE_DEPTH = 256;
    localparam int COSH_SPAN        = COSH_TABLE_DEPTH - 1;
    localparam int COSH_IDX_W       = $clog2(COSH_TABLE_DEPTH);
    localparam int COSH_W           = 16;

    localparam int KEY_W  = 16;
    localparam int PT_W   = 20;
    localparam int ETA_W  = 15;
    localparam int SIE_W  = 16;
    localparam int HOE_W  = 16;
    localparam int DETA_W = 16;
    localparam int DPHI_W = 17;
    localparam int ISO_W  = 20;
    localparam int WP_W   = 2;

    localparam int ETA_SAT    = 12288;
    localparam int ASAT_W     = $clog2(ETA_SAT + 1);
    localparam int ETA_PROD_W = $clog2(ETA_SAT * COSH_SPAN + ETA_SAT / 2 + 1);
    localparam int ETA_Q_W    = ETA_PROD_W - 12;
    localparam int DIV3_SHIFT = 17;
    localparam int DIV3_MUL   = 43691;
    localparam int DIV3_MUL_W = 16;
    localparam int DIV3_W     = ETA_Q_W + DIV3_MUL_W;

    localparam int E_RAW_W = PT_W + COSH_W;
    localparam int E_W     = E_RAW_W + 1 - 12;
    localparam int C_W     = 17;
    localparam int PROD_W  = C_W + E_W;

    localparam logic [ETA_W-1:0]  BARREL_ETA_LIM = 15'd6058;
    localparam logic [SIE_W-1:0]  SIEIE_EB_LIM   = 16'd984;
    localparam logic [SIE_W-1:0]  SIEIE_EE_LIM   = 16'd2950;
    localparam logic [HOE_W-1:0]  HOE_LIM        = 16'd205;
    localparam logic [DETA_W-1:0] DETA_EB_LIM    = 16'd525;
    localparam logic [DETA_W-1:0] DETA_EE_LIM    = 16'd787;
    localparam logic [DPHI_W-1:0] DPHI_LIM       = 17'd984;
    localparam logic [E_W-1:0]    E_MIN          = E_W'(64);

    localparam logic [C_W-1:0] C_ECAL_EB     = 17'd16384;
    localparam logic [C_W-1:0] C_ECAL_EE     = 17'd6554;
    localparam logic [C_W-1:0] C_TRK         = 17'd66;
    localparam logic [C_W-1:0] C_HCAL_ELE_EB = 17'd26214;
    localparam logic [C_W-1:0] C_HCAL_ELE_EE = 17'd39322;
    localparam logic [C_W-1:0] C_HCAL_PHO_EB = 17'd39322;
    localparam logic [C_W-1:0] C_HCAL_PHO_EE = 17'd65536;

    localparam logic [WP_W-1:0] WP_ELE_REC = 2'd0;

    typedef logic [COSH_W-1:0] t_cosh_rom [COSH_TABLE_DEPTH];

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             cand_ok;
        logic             barrel;
        logic [ISO_W-1:0] ecal;
        logic [ISO_W-1:0] hcal;
        logic [ISO_W-1:0] trk;
    } t_carry;

    // Even Taylor sum in Q30, rounded to Q4.12
    function automatic t_cosh_rom f_build_cosh();
        t_cosh_rom       rom;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i < COSH_TABLE_DEPTH; i++) begin
            term = 64'd1 << 30;
            sum  = term;
            for (int n = 1; n <= 64; n++) begin
                term = term * 64'(3 * i) / 64'(n * COSH_SPAN);
                if ((n % 2) == 0) begin
                    sum = sum + term;
                end
            end
            rom[i] = COSH_W'((sum + (64'd1 << 17)) >> 18);
        end
        return rom;
    endfunction

    localparam t_cosh_rom COSH_ROM = f_build_cosh();

endpackage

### design/ecid_index.sv
// Front stages: basic cuts, cosh index and cosh table read.
module ecid_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ecid_pkg::WP_W-1:0]     i_working_point,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ecid_pkg::KEY_W-1:0]    i_candidate_key,
    input  logic                          i_candidate_valid,
    input  logic [ecid_pkg::PT_W-1:0]     i_pt,
    input  logic signed [ecid_pkg::ETA_W-1:0]  i_eta,
    input  logic [ecid_pkg::SIE_W-1:0]    i_sigma_ieta_ieta,
    input  logic [ecid_pkg::HOE_W-1:0]    i_h_over_e,
    input  logic signed [ecid_pkg::DETA_W-1:0] i_delta_eta_in,
    input  logic signed [ecid_pkg::DPHI_W-1:0] i_delta_phi_in,
    input  logic [ecid_pkg::ISO_W-1:0]    i_ecal_isolation,
    input  logic [ecid_pkg::ISO_W-1:0]    i_hcal_isolation,
    input  logic [ecid_pkg::ISO_W-1:0]    i_track_isolation,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ecid_pkg::t_carry              o_carry,
    output logic [ecid_pkg::PT_W-1:0]     o_pt,
    output logic [ecid_pkg::COSH_W-1:0]   o_cosh
);
    import ecid_pkg::*;

    logic [ETA_W-1:0]      w_aeta;
    logic [DETA_W-1:0]     w_adeta;
    logic [DPHI_W-1:0]     w_adphi;
    logic [ASAT_W-1:0]     w_asat;
    logic                  w_barrel;
    logic                  w_photon;
    logic                  w_track_ok;
    logic                  w_shape_ok;
    t_carry                n_carry1;
    logic [ETA_PROD_W-1:0] n_prod1;
    logic [DIV3_W-1:0]     w_div3;
    logic                  w_adv1;
    logic                  w_adv2;
    logic                  w_adv3;

    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    t_carry                r_carry1;
    t_carry                r_carry2;
    t_carry                r_carry3;
    logic [PT_W-1:0]       r_pt1;
    logic [PT_W-1:0]       r_pt2;
    logic [PT_W-1:0]       r_pt3;
    logic [ETA_PROD_W-1:0] r_prod1;
    logic [COSH_IDX_W-1:0] r_idx2;
    logic [COSH_W-1:0]     r_cosh3;

    always_comb begin
        w_aeta   = i_eta[ETA_W-1] ? ETA_W'(-i_eta) : ETA_W'(i_eta);
        w_adeta  = i_delta_eta_in[DETA_W-1] ? DETA_W'(-i_delta_eta_in)
                                            : DETA_W'(i_delta_eta_in);
        w_adphi  = i_delta_phi_in[DPHI_W-1] ? DPHI_W'(-i_delta_phi_in)
                                            : DPHI_W'(i_delta_phi_in);
        w_asat   = (w_aeta > ETA_W'(ETA_SAT)) ? ASAT_W'(ETA_SAT) : ASAT_W'(w_aeta);
        w_barrel = w_aeta < BARREL_ETA_LIM;
        w_photon = i_working_point[1];
        w_shape_ok = (i_sigma_ieta_ieta < (w_barrel ? SIEIE_EB_LIM : SIEIE_EE_LIM))
                     && (i_h_over_e < HOE_LIM);
        w_track_ok = (w_adeta < (w_barrel ? DETA_EB_LIM : DETA_EE_LIM))
                     && (w_adphi < DPHI_LIM);

        n_carry1.key     = i_candidate_key;
        n_carry1.cand_ok = i_candidate_valid && w_shape_ok && (w_photon || w_track_ok);
        n_carry1.barrel  = w_barrel;
        n_carry1.ecal    = i_ecal_isolation;
        n_carry1.hcal    = i_hcal_isolation;
        n_carry1.trk     = i_track_isolation;

        n_prod1 = ETA_PROD_W'(w_asat) * ETA_PROD_W'(COSH_SPAN) + ETA_PROD_W'(ETA_SAT / 2);

        // divide by 3 through the reciprocal, exact for this range
        w_div3 = DIV3_W'(r_prod1[ETA_PROD_W-1:12]) * DIV3_W'(DIV3_MUL);
    end

    assign w_adv3  = !r_v3 || i_ready;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_carry1 <= n_carry1;
            r_pt1    <= i_pt;
            r_prod1  <= n_prod1;
        end
        if (w_adv2) begin
            r_carry2 <= r_carry1;
            r_pt2    <= r_pt1;
            r_idx2   <= w_div3[DIV3_SHIFT+COSH_IDX_W-1:DIV3_SHIFT];
        end
        if (w_adv3) begin
            r_carry3 <= r_carry2;
            r_pt3    <= r_pt2;
            r_cosh3  <= COSH_ROM[r_idx2];
        end
    end

    assign o_valid = r_v3;
    assign o_carry = r_carry3;
    assign o_pt    = r_pt3;
    assign o_cosh  = r_cosh3;

endmodule

### design/ecid_energy.sv
// Energy stages: pt times cosh, rounding and the E_MIN floor.
module ecid_energy (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ecid_pkg::t_carry            i_carry,
    input  logic [ecid_pkg::PT_W-1:0]   i_pt,
    input  logic [ecid_pkg::COSH_W-1:0] i_cosh,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ecid_pkg::t_carry            o_carry,
    output logic [ecid_pkg::E_W-1:0]    o_energy
);
    import ecid_pkg::*;

    logic [E_RAW_W:0]  w_round;
    logic [E_W-1:0]    w_energy;
    logic              w_adv4;
    logic              w_adv5;

    logic              r_v4;
    logic              r_v5;
    t_carry            r_carry4;
    t_carry            r_carry5;
    logic [E_RAW_W-1:0] r_raw4;
    logic [E_W-1:0]    r_energy5;

    always_comb begin
        w_round  = (E_RAW_W + 1)'(r_raw4) + (E_RAW_W + 1)'(2048);
        w_energy = w_round[E_RAW_W:12];
        if (w_energy < E_MIN) begin
            w_energy = E_MIN;
        end
    end

    assign w_adv5  = !r_v5 || i_ready;
    assign w_adv4  = !r_v4 || w_adv5;
    assign o_ready = w_adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_adv4) begin
                r_v4 <= i_valid;
            end
            if (w_adv5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_carry4 <= i_carry;
            r_raw4   <= E_RAW_W'(i_pt) * E_RAW_W'(i_cosh);
        end
        if (w_adv5) begin
            r_carry5  <= r_carry4;
            r_energy5 <= w_energy;
        end
    end

    assign o_valid  = r_v5;
    assign o_carry  = r_carry5;
    assign o_energy = r_energy5;

endmodule

### design/ecid_ratio.sv
// Ratio stages: isolation over energy products, final decision and output register.
module ecid_ratio (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ecid_pkg::WP_W-1:0]  i_working_point,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  ecid_pkg::t_carry           i_carry,
    input  logic [ecid_pkg::E_W-1:0]   i_energy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ecid_pkg::KEY_W-1:0] o_result_key,
    output logic                       o_keep
);
    import ecid_pkg::*;

    logic              w_photon;
    logic              w_custom;
    logic [C_W-1:0]    w_c_ecal;
    logic [C_W-1:0]    w_c_hcal;
    logic              w_ecal_ok;
    logic              w_hcal_ok;
    logic              w_trk_ok;
    logic              n_keep;
    logic              w_adv6;
    logic              w_adv7;

    logic              r_v6;
    logic              r_v7;
    t_carry            r_carry6;
    logic [PROD_W-1:0] r_ecal_lim6;
    logic [PROD_W-1:0] r_hcal_lim6;
    logic [PROD_W-1:0] r_trk_lim6;
    logic [KEY_W-1:0]  r_key7;
    logic              r_keep7;

    always_comb begin
        w_photon = i_working_point[1];
        w_custom = i_working_point[0];
        w_c_ecal = i_carry.barrel ? C_ECAL_EB : C_ECAL_EE;
        if (w_photon) begin
            w_c_hcal = i_carry.barrel ? C_HCAL_PHO_EB : C_HCAL_PHO_EE;
        end else begin
            w_c_hcal = i_carry.barrel ? C_HCAL_ELE_EB : C_HCAL_ELE_EE;
        end

        w_ecal_ok = PROD_W'({r_carry6.ecal, 16'd0}) < r_ecal_lim6;
        w_hcal_ok = PROD_W'({r_carry6.hcal, 16'd0}) < r_hcal_lim6;
        w_trk_ok  = PROD_W'({r_carry6.trk, 16'd0}) < r_trk_lim6;
        n_keep    = r_carry6.cand_ok && w_ecal_ok && (w_photon || w_trk_ok)
                    && (!w_custom || w_hcal_ok);
    end

    assign w_adv7  = !r_v7 || i_ready;
    assign w_adv6  = !r_v6 || w_adv7;
    assign o_ready = w_adv6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (w_adv6) begin
                r_v6 <= i_valid;
            end
            if (w_adv7) begin
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv6) begin
            r_carry6    <= i_carry;
            r_ecal_lim6 <= PROD_W'(w_c_ecal) * PROD_W'(i_energy);
            r_hcal_lim6 <= PROD_W'(w_c_hcal) * PROD_W'(i_energy);
            r_trk_lim6  <= PROD_W'(C_TRK) * PROD_W'(i_energy);
        end
        if (w_adv7) begin
            r_key7  <= r_carry6.key;
            r_keep7 <= n_keep;
        end
    end

    assign o_valid      = r_v7;
    assign o_result_key = r_key7;
    assign o_keep       = r_keep7;

endmodule

### design/electron_cut_id_selector.sv
// Top level of the electron/photon cut-based ID selector.
//
//   channel   direction  handshake                 payload
//   input     in         i_valid / o_ready         i_candidate_key .. i_track_isolation
//   result    out        o_valid / i_ready         o_result_key, o_keep
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_working_point
//
// One item per cycle sustained while i_ready stays high, through seven register stages
// (eta product, cosh index, table read, pt*cosh, rounding, ratio products, decision).
// Synchronous active-low reset clears all stage valid bits and sets working point 0.
// Each stage holds only while its successor is full and blocked, so bubbles fill
// and the input stays open while a result waits, until all seven stages are full.
module electron_cut_id_selector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ecid_pkg::WP_W-1:0]          i_cfg_working_point,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ecid_pkg::KEY_W-1:0]         i_candidate_key,
    input  logic                               i_candidate_valid,
    input  logic [ecid_pkg::PT_W-1:0]          i_pt,
    input  logic signed [ecid_pkg::ETA_W-1:0]  i_eta,
    input  logic [ecid_pkg::SIE_W-1:0]         i_sigma_ieta_ieta,
    input  logic [ecid_pkg::HOE_W-1:0]         i_h_over_e,
    input  logic signed [ecid_pkg::DETA_W-1:0] i_delta_eta_in,
    input  logic signed [ecid_pkg::DPHI_W-1:0] i_delta_phi_in,
    input  logic [ecid_pkg::ISO_W-1:0]         i_ecal_isolation,
    input  logic [ecid_pkg::ISO_W-1:0]         i_hcal_isolation,
    input  logic [ecid_pkg::ISO_W-1:0]         i_track_isolation,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ecid_pkg::KEY_W-1:0]         o_result_key,
    output logic                               o_keep
);
    import ecid_pkg::*;

    logic [WP_W-1:0]   r_working_point;
    logic              w_idx_valid;
    logic              w_idx_ready;
    t_carry            w_idx_carry;
    logic [PT_W-1:0]   w_idx_pt;
    logic [COSH_W-1:0] w_idx_cosh;
    logic              w_eng_valid;
    logic              w_eng_ready;
    t_carry            w_eng_carry;
    logic [E_W-1:0]    w_eng_energy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_working_point <= WP_ELE_REC;
        end else if (i_cfg_valid) begin
            r_working_point <= i_cfg_working_point;
        end
    end

    ecid_index u_index (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_working_point   (r_working_point),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_candidate_key   (i_candidate_key),
        .i_candidate_valid (i_candidate_valid),
        .i_pt              (i_pt),
        .i_eta             (i_eta),
        .i_sigma_ieta_ieta (i_sigma_ieta_ieta),
        .i_h_over_e        (i_h_over_e),
        .i_delta_eta_in    (i_delta_eta_in),
        .i_delta_phi_in    (i_delta_phi_in),
        .i_ecal_isolation  (i_ecal_isolation),
        .i_hcal_isolation  (i_hcal_isolation),
        .i_track_isolation (i_track_isolation),
        .o_valid           (w_idx_valid),
        .i_ready           (w_idx_ready),
        .o_carry           (w_idx_carry),
        .o_pt              (w_idx_pt),
        .o_cosh            (w_idx_cosh)
    );

    ecid_energy u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_idx_valid),
        .o_ready  (w_idx_ready),
        .i_carry  (w_idx_carry),
        .i_pt     (w_idx_pt),
        .i_cosh   (w_idx_cosh),
        .o_valid  (w_eng_valid),
        .i_ready  (w_eng_ready),
        .o_carry  (w_eng_carry),
        .o_energy (w_eng_energy)
    );

    ecid_ratio u_ratio (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_working_point (r_working_point),
        .i_valid         (w_eng_valid),
        .o_ready         (w_eng_ready),
        .i_carry         (w_eng_carry),
        .i_energy        (w_eng_energy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_key    (o_result_key),
        .o_keep          (o_keep)
    );

endmodule
